@@ hdl/led_pkg.sv @@
package led_pkg;

   localparam int BYTE_W = 8;
   localparam int CAP_W = 9;
   localparam int IDX_W = 8;
   localparam int STEP_W = 3;

   localparam int MARK_LIMIT = 256;
   localparam int MAX_LINE_DEFAULT = 256;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam logic [BYTE_W-1:0] CHAR_BS = 8'd8;
   localparam logic [BYTE_W-1:0] CHAR_DEL = 8'd127;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_CARET = 8'd94;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;
   localparam logic [BYTE_W-1:0] CTRL_OFFSET = 8'd64;
   localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;

   typedef enum logic [2:0] {
      KIND_PLAIN,
      KIND_CARET,
      KIND_NEWLINE,
      KIND_ERASE_PRINT,
      KIND_ERASE_CTRL
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [BYTE_W-1:0] rx_byte;
      logic [IDX_W-1:0] store_index;
      logic line_done;
      logic [CAP_W-1:0] line_length;
   } cmd_type;

   function automatic logic [STEP_W-1:0] run_len(input kind_type k);
      logic [STEP_W-1:0] n;
      case (k)
         KIND_PLAIN: n = 3'd1;
         KIND_CARET: n = 3'd2;
         KIND_NEWLINE: n = 3'd3;
         KIND_ERASE_PRINT: n = 3'd3;
         KIND_ERASE_CTRL: n = 3'd6;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] echo_char(input kind_type k,
                                                   input logic [STEP_W-1:0] step,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      case (k)
         KIND_ERASE_CTRL: c = (step == 3'd2 || step == 3'd3) ? CHAR_SPACE : CHAR_BS;
         KIND_ERASE_PRINT: c = (step == 3'd1) ? CHAR_SPACE : CHAR_BS;
         KIND_NEWLINE: c = (step == 3'd2) ? CHAR_LF : CHAR_CR;
         KIND_CARET: begin
            if (step == 3'd0) c = CHAR_CARET;
            else if (b == CHAR_NUL) c = CHAR_ZERO;
            else c = CTRL_OFFSET + b;
         end
         default: c = b;
      endcase
      return c;
   endfunction

endpackage

@@ hdl/led_front.sv @@
module led_front #(
   parameter int MAX_LINE = led_pkg::MAX_LINE_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [led_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic csr_write_enable,
   input  logic [led_pkg::CAP_W-1:0] csr_write_data,
   output logic push_valid,
   input  logic push_ready,
   output led_pkg::cmd_type push_cmd
);
   import led_pkg::*;

   localparam int MARK_DEPTH = (MAX_LINE < MARK_LIMIT) ? MAX_LINE : MARK_LIMIT;
   localparam int POS_W = $clog2(MARK_DEPTH);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CAP_W-1:0] cap_ff;
   logic marks_ff [MARK_DEPTH];
   logic mark_rd_ff;

   logic [CAP_W-1:0] eff_cap;
   logic [CAP_W-1:0] next_count;
   logic [BYTE_W-1:0] stored;
   logic is_erase, at_zero, accept, mark_we, mark_wdata;
   logic [POS_W-1:0] rd_addr;

   // capacity clamped to 1 .. mark depth
   always_comb begin
      if (cap_ff == '0) eff_cap = CAP_W'(1);
      else if (cap_ff > CAP_W'(MARK_DEPTH)) eff_cap = CAP_W'(MARK_DEPTH);
      else eff_cap = cap_ff;
   end

   assign is_erase = (req_rx_byte == CHAR_BS) || (req_rx_byte == CHAR_DEL);
   assign at_zero = (pos_ff == '0);
   assign stored = (req_rx_byte == CHAR_CR) ? CHAR_LF : req_rx_byte;
   assign next_count = CAP_W'(pos_ff) + CAP_W'(1);

   assign req_ready = push_ready;
   assign push_valid = req_valid && !(is_erase && at_zero);
   assign accept = req_valid && req_ready;
   assign mark_we = accept && !is_erase;
   assign mark_wdata = (stored < CTRL_LIMIT);

   always_comb begin
      push_cmd = '0;
      push_cmd.rx_byte = req_rx_byte;
      pos_in = pos_ff;
      priority if (is_erase) begin
         push_cmd.kind = mark_rd_ff ? KIND_ERASE_CTRL : KIND_ERASE_PRINT;
         if (accept && !at_zero) pos_in = pos_ff - POS_W'(1);
      end else begin
         if (req_rx_byte == CHAR_CR) push_cmd.kind = KIND_NEWLINE;
         else if (req_rx_byte < CTRL_LIMIT) push_cmd.kind = KIND_CARET;
         else push_cmd.kind = KIND_PLAIN;
         push_cmd.store_index = IDX_W'(pos_ff);
         push_cmd.line_done = (req_rx_byte == CHAR_CR) || (next_count >= eff_cap);
         push_cmd.line_length = push_cmd.line_done ? next_count : '0;
         if (accept) pos_in = push_cmd.line_done ? '0 : next_count[POS_W-1:0];
      end
   end

   // keep the mark of the last stored char prefetched
   assign rd_addr = (pos_in == '0) ? '0 : pos_in - POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cap_ff <= CAP_RESET;
      end else begin
         pos_ff <= pos_in;
         if (csr_write_enable) cap_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) marks_ff[pos_ff] <= mark_wdata;
      if (mark_we && (pos_ff == rd_addr)) mark_rd_ff <= mark_wdata;
      else mark_rd_ff <= marks_ff[rd_addr];
   end

   a_erase_at_zero_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && is_erase && at_zero) |-> !push_valid)
      else $error("erase at position zero queued a command");

   a_done_clears_position: assert property (@(posedge clock) disable iff (reset)
      (accept && push_valid && push_cmd.line_done) |=> (pos_ff == '0))
      else $error("position not cleared after line completion");

endmodule

@@ hdl/led_queue.sv @@
module led_queue #(
   parameter int DEPTH = led_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  led_pkg::cmd_type in_cmd,
   output logic out_valid,
   input  logic out_ready,
   output led_pkg::cmd_type out_cmd
);
   import led_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop) rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_cmd;
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count overflow");

endmodule

@@ hdl/led_back.sv @@
module led_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   output logic head_ready,
   input  led_pkg::cmd_type head_cmd,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [led_pkg::BYTE_W-1:0] rsp_echo_byte,
   output logic rsp_last_of_run,
   output logic rsp_store_valid,
   output logic [led_pkg::IDX_W-1:0] rsp_store_index,
   output logic [led_pkg::BYTE_W-1:0] rsp_store_value,
   output logic rsp_line_done,
   output logic [led_pkg::CAP_W-1:0] rsp_line_length
);
   import led_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic valid_ff, valid_in;
   logic [BYTE_W-1:0] echo_ff, store_value_ff;
   logic last_ff, store_valid_ff, done_ff;
   logic [IDX_W-1:0] store_index_ff;
   logic [CAP_W-1:0] length_ff;

   logic load, take, is_last, is_store;

   assign load = !valid_ff || rsp_ready;
   assign take = head_valid && load;
   assign is_last = (step_ff == run_len(head_cmd.kind) - STEP_W'(1));
   assign head_ready = take && is_last;
   assign is_store = (head_cmd.kind != KIND_ERASE_CTRL) &&
                     (head_cmd.kind != KIND_ERASE_PRINT);

   always_comb begin
      step_in = step_ff;
      valid_in = valid_ff;
      if (load) valid_in = head_valid;
      if (take) step_in = is_last ? '0 : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff <= step_in;
      end
   end

   // echo byte on every step; store and line fields only on the last byte of a run
   always_ff @(posedge clock) begin
      if (take) begin
         echo_ff <= echo_char(head_cmd.kind, step_ff, head_cmd.rx_byte);
         last_ff <= is_last;
         store_valid_ff <= is_last && is_store;
         store_index_ff <= (is_last && is_store) ? head_cmd.store_index : '0;
         if (is_last && is_store)
            store_value_ff <= (head_cmd.kind == KIND_NEWLINE) ? CHAR_LF : head_cmd.rx_byte;
         else
            store_value_ff <= '0;
         done_ff <= is_last && head_cmd.line_done;
         length_ff <= (is_last && head_cmd.line_done) ? head_cmd.line_length : '0;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_echo_byte = echo_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_store_valid = store_valid_ff;
   assign rsp_store_index = store_index_ff;
   assign rsp_store_value = store_value_ff;
   assign rsp_line_done = done_ff;
   assign rsp_line_length = length_ff;

   a_step_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (step_ff < run_len(head_cmd.kind)))
      else $error("echo step beyond run length");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (done_ff || store_valid_ff)) |-> last_ff)
      else $error("line or store flag away from last echo byte");

endmodule

@@ hdl/line_editor_with_echo.sv @@
// Line editor with echo: each received byte (req_ transaction) is classified, a non-erase byte is stored
// at the current line position, and a run of echo bytes leaves on the rsp_ channel, one byte per
// transaction; the last byte of a run carries last_of_run plus the store and line-complete
// fields. A request is taken whenever the command queue has room (QUEUE_DEPTH
// commands), so requests may arrive back to back; the response side moves one echo byte per
// cycle while rsp_ready holds, and a run is 1 byte for a printable byte, 2 for a control
// byte, 3 for CR or erasing a printable char, 6 for erasing a control char. Erase (8 or 127)
// at position zero is taken and produces no response. csr_write_data sets the line capacity
// (reset 256, 0 acts as 1, clamped to min(MAX_LINE, 256)); write it only while idle. The
// per-position control marks live in a plain memory with no clearing after reset.
module line_editor_with_echo #(
   parameter int MAX_LINE = led_pkg::MAX_LINE_DEFAULT,
   parameter int QUEUE_DEPTH = led_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_valid,
   output logic req_ready,
   input  logic [led_pkg::BYTE_W-1:0] req_rx_byte,
   // capacity register
   input  logic csr_write_enable,
   input  logic [led_pkg::CAP_W-1:0] csr_write_data,
   // response channel
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [led_pkg::BYTE_W-1:0] rsp_echo_byte,
   output logic rsp_last_of_run,
   output logic rsp_store_valid,
   output logic [led_pkg::IDX_W-1:0] rsp_store_index,
   output logic [led_pkg::BYTE_W-1:0] rsp_store_value,
   output logic rsp_line_done,
   output logic [led_pkg::CAP_W-1:0] rsp_line_length
);
   import led_pkg::*;

   // front to queue
   logic push_valid, push_ready;
   cmd_type push_cmd;
   // queue to back
   logic head_valid, head_ready;
   cmd_type head_cmd;

   // front: classify, track position and marks, build one command per request, none for an erase at position zero
   led_front #(
      .MAX_LINE(MAX_LINE)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd)
   );

   // short command queue so front and back stall independently
   led_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .in_valid(push_valid),
      .in_ready(push_ready),
      .in_cmd(push_cmd),
      .out_valid(head_valid),
      .out_ready(head_ready),
      .out_cmd(head_cmd)
   );

   // back: step through the echo run into the response register
   led_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_ready(head_ready),
      .head_cmd(head_cmd),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_echo_byte(rsp_echo_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_store_valid(rsp_store_valid),
      .rsp_store_index(rsp_store_index),
      .rsp_store_value(rsp_store_value),
      .rsp_line_done(rsp_line_done),
      .rsp_line_length(rsp_line_length)
   );

endmodule

@@ verif/line_editor_with_echo_tb.sv @@
module line_editor_with_echo_tb;
   import led_pkg::*;

   // one echo byte as it leaves the rsp_ channel
   typedef struct packed {
      logic [BYTE_W-1:0] echo_byte;
      logic last_of_run;
      logic store_valid;
      logic [IDX_W-1:0] store_index;
      logic [BYTE_W-1:0] store_value;
      logic line_done;
      logic [CAP_W-1:0] line_length;
   } echo_beat_type;

   typedef logic [BYTE_W-1:0] key_queue_type [$];

   // tracks the line being typed and the echo bytes each keystroke must produce
   class echo_ledger_type;
      logic [CAP_W-1:0] capacity;
      int unsigned position;
      bit ctrl_mark [MARK_LIMIT];
      echo_beat_type awaited_echoes [$];
      int unsigned mismatches;

      function new();
         capacity = CAP_RESET;
         position = 0;
         mismatches = 0;
      endfunction

      function void set_capacity(input logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int unsigned outstanding();
         return awaited_echoes.size();
      endfunction

      // accepted request transaction: work out its echo run and line bookkeeping
      function void take_keystroke(input logic [BYTE_W-1:0] key);
         logic [BYTE_W-1:0] run [$];
         logic [BYTE_W-1:0] kept;
         logic [IDX_W-1:0] slot;
         int unsigned limit;
         bit stores;
         bit done;
         int unsigned length;
         echo_beat_type beat;
         kept = key;
         stores = 1'b0;
         done = 1'b0;
         length = 0;
         slot = '0;
         if (key == CHAR_BS || key == CHAR_DEL) begin
            // rubout at column zero is swallowed without any echo
            if (position == 0) return;
            position--;
            if (ctrl_mark[position]) begin
               run = '{CHAR_BS, CHAR_BS, CHAR_SPACE, CHAR_SPACE, CHAR_BS, CHAR_BS};
            end else begin
               run = '{CHAR_BS, CHAR_SPACE, CHAR_BS};
            end
         end else begin
            if (key == CHAR_CR) begin
               run = '{CHAR_CR, CHAR_CR, CHAR_LF};
               kept = CHAR_LF;
            end else if (key == CHAR_NUL) begin
               run = '{CHAR_CARET, CHAR_ZERO};
            end else if (key < CTRL_LIMIT) begin
               run = '{CHAR_CARET, CTRL_OFFSET + key};
            end else begin
               run = '{key};
            end
            stores = 1'b1;
            slot = IDX_W'(position % MARK_LIMIT);
            ctrl_mark[slot] = (kept < CTRL_LIMIT);
            position = slot + 1;
            limit = capacity;
            if (limit < 1) limit = 1;
            if (limit > MAX_LINE_DEFAULT) limit = MAX_LINE_DEFAULT;
            if (limit > MARK_LIMIT) limit = MARK_LIMIT;
            if (key == CHAR_CR || position >= limit) begin
               done = 1'b1;
               length = position;
               position = 0;
            end
         end
         foreach (run[i]) begin
            beat = '0;
            beat.echo_byte = run[i];
            if (i == run.size() - 1) begin
               beat.last_of_run = 1'b1;
               beat.store_valid = stores;
               if (stores) begin
                  beat.store_index = slot;
                  beat.store_value = kept;
               end
               beat.line_done = done;
               beat.line_length = CAP_W'(length);
            end
            awaited_echoes.push_back(beat);
         end
      endfunction

      function void compare(input string field, input logic [15:0] want,
                            input logic [15:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            mismatches++;
         end
      endfunction

      // accepted response transaction against the oldest pending echo byte
      function void check_echo(input echo_beat_type seen);
         echo_beat_type want;
         if (awaited_echoes.size() == 0) begin
            $error("echo_byte: expected nothing, got %0d", seen.echo_byte);
            mismatches++;
            return;
         end
         want = awaited_echoes.pop_front();
         compare("echo_byte", want.echo_byte, seen.echo_byte);
         compare("last_of_run", want.last_of_run, seen.last_of_run);
         compare("store_valid", want.store_valid, seen.store_valid);
         compare("store_index", want.store_index, seen.store_index);
         compare("store_value", want.store_value, seen.store_value);
         compare("line_done", want.line_done, seen.line_done);
         compare("line_length", want.line_length, seen.line_length);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic csr_write_enable = 1'b0;
   logic [CAP_W-1:0] csr_write_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_echo_byte;
   logic rsp_last_of_run;
   logic rsp_store_valid;
   logic [IDX_W-1:0] rsp_store_index;
   logic [BYTE_W-1:0] rsp_store_value;
   logic rsp_line_done;
   logic [CAP_W-1:0] rsp_line_length;

   // when set, neither side idles or stalls
   bit steady = 1'b0;
   echo_ledger_type ledger;

   line_editor_with_echo dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_echo_byte(rsp_echo_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_store_valid(rsp_store_valid),
      .rsp_store_index(rsp_store_index),
      .rsp_store_value(rsp_store_value),
      .rsp_line_done(rsp_line_done),
      .rsp_line_length(rsp_line_length)
   );

   // 8 unit period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver back-pressure, about one stall cycle in five
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady || ($urandom_range(99) >= 20);
   end

   // outputs are stable at the falling edge, so a transaction seen here
   // completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ledger.check_echo({rsp_echo_byte, rsp_last_of_run, rsp_store_valid,
                            rsp_store_index, rsp_store_value, rsp_line_done,
                            rsp_line_length});
      end
   end

   // one request transaction, called and returning on a rising edge;
   // valid stays high into the next key unless an idle gap follows
   task automatic send_byte(input logic [BYTE_W-1:0] key);
      req_valid <= 1'b1;
      req_rx_byte <= key;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      ledger.take_keystroke(key);
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_burst(input key_queue_type keys);
      foreach (keys[i]) send_byte(keys[i]);
      req_valid <= 1'b0;
   endtask

   // wait for every echo byte, then give swallowed rubouts time to drain
   task automatic settle();
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ledger.set_capacity(value);
   endtask

   // mostly text with edits and line ends, some control and high bytes
   function automatic logic [BYTE_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) return BYTE_W'($urandom_range(32, 126));
      if (roll < 45) return BYTE_W'($urandom_range(128, 255));
      if (roll < 55) return CHAR_BS;
      if (roll < 62) return CHAR_DEL;
      if (roll < 72) return CHAR_CR;
      if (roll < 87) return BYTE_W'($urandom_range(0, 31));
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // short lines dominate, with the clamp cases thrown in
   function automatic logic [CAP_W-1:0] pick_capacity();
      case ($urandom_range(9))
         0: return 9'd0;
         1: return 9'd1;
         2: return 9'd511;
         3: return 9'd256;
         8: return CAP_W'($urandom_range(13, 40));
         9: return CAP_W'($urandom_range(0, 511));
         default: return CAP_W'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin
      key_queue_type keys;
      ledger = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: printable rubout, rubouts at column zero, caret forms,
      // raw high bytes, then unwind the line including a control char erase
      send_burst('{8'd65, CHAR_BS, CHAR_BS, CHAR_DEL, CHAR_NUL, 8'd1, 8'd31, 8'd255,
                   8'd128, 8'd126, 8'd32, CHAR_BS, CHAR_DEL, CHAR_BS, CHAR_BS, CHAR_BS,
                   CHAR_CR});
      settle();

      // one char per line, including a line end and a swallowed rubout
      write_capacity(9'd1);
      send_burst('{8'd122, CHAR_CR, CHAR_BS});
      settle();

      // zero behaves as one
      write_capacity(9'd0);
      send_burst('{8'd7});
      settle();

      // above the mark depth clamps, then capacity drops below the position
      write_capacity(9'd511);
      send_burst('{8'd97, 8'd98, 8'd99});
      settle();
      write_capacity(9'd2);
      send_burst('{8'd100});
      settle();

      // random phases, capacity changed between them, one without any idling
      for (int phase = 0; phase < 6; phase++) begin
         write_capacity(pick_capacity());
         steady = (phase == 2);
         keys.delete();
         repeat (15) keys.push_back(pick_key());
         send_burst(keys);
         settle();
      end
      steady = 1'b0;

      if (ledger.mismatches == 0) begin
         $display("line_editor_with_echo_tb: done, clean");
      end else begin
         $display("line_editor_with_echo_tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1600000;
      $display("line_editor_with_echo_tb: done, errors");
      $finish;
   end

endmodule
